// ===== design/dmtr_pkg.sv =====
`default_nettype none
package dmtr_pkg;

	localparam int NUM_REGS = 20;
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 2;

	localparam logic [31:0] TIDR_RST = 32'h0000_0015;
	localparam logic [31:0] TISTAT_RST = 32'h0000_0001;
	localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
	localparam logic [23:0] OCR_MASK = 24'hff_ffff;

	typedef enum logic [1:0] {
		MODE_READ = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_TICK = 2'd2
	} mode_t;

	typedef enum logic [4:0] {
		R_TIDR = 5'd0,
		R_TIOCP = 5'd1,
		R_TISTAT = 5'd2,
		R_TISR = 5'd3,
		R_TIER = 5'd4,
		R_TWER = 5'd5,
		R_TCLR = 5'd6,
		R_TCRR = 5'd7,
		R_TLDR = 5'd8,
		R_TTGR = 5'd9,
		R_TWPS = 5'd10,
		R_TMAR = 5'd11,
		R_TCAR1 = 5'd12,
		R_TSICR = 5'd13,
		R_TCAR2 = 5'd14,
		R_TPIR = 5'd15,
		R_TNIR = 5'd16,
		R_TCVR = 5'd17,
		R_TOCR = 5'd18,
		R_TOWR = 5'd19
	} reg_idx_t;

	localparam int TCLR_EN_BIT = 0;
	localparam int TCLR_AR_BIT = 1;
	localparam int TCLR_CE_BIT = 6;
	localparam int TIER_MATCH_BIT = 0;
	localparam int TIER_OVF_BIT = 1;
	localparam int TISR_MATCH_BIT = 0;
	localparam int TISR_OVF_BIT = 1;
	localparam int TIOCP_SRST_BIT = 0;
	localparam int TIOCP_RD_MASK_BIT = 1;
	localparam int TSICR_SFT_BIT = 1;

	typedef struct packed {
		mode_t mode;
		logic [4:0] reg_index;
		logic [31:0] write_data;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic irq_pulse;
		logic unmapped;
	} result_t;

	function automatic logic [31:0] reg_default(input int unsigned i);
		logic [31:0] v;
		v = '0;
		if (i == int'(R_TIDR)) begin
			v = TIDR_RST;
		end else if (i == int'(R_TISTAT)) begin
			v = TISTAT_RST;
		end else if (i == int'(R_TTGR)) begin
			v = ALL_ONES;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== design/dmtr_in_reg.sv =====
`default_nettype none
module dmtr_in_reg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire dmtr_pkg::item_t in_item,
	input wire logic advance,
	output logic valid_s1,
	output dmtr_pkg::item_t item_s1
);
	import dmtr_pkg::*;

	logic vld_s1;
	item_t itm_s1;

	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			itm_s1 <= in_item;
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1 = itm_s1;
endmodule
`default_nettype wire

// ===== design/dmtr_regs.sv =====
`default_nettype none
module dmtr_regs #(
	parameter int unsigned TICK_STEP = 24000
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire dmtr_pkg::item_t item,
	output dmtr_pkg::result_t result
);
	import dmtr_pkg::*;

	localparam logic [31:0] STEP = 32'(TICK_STEP);
	localparam logic [31:0] OVF_LIMIT = ALL_ONES - STEP;

	logic [31:0] bank_q [NUM_REGS];
	logic [31:0] bank_d [NUM_REGS];
	logic armed_q;
	logic armed_d;

	logic mapped;
	logic [31:0] rd_val;
	logic [31:0] cr;
	logic [31:0] nv;
	logic [31:0] mar;
	logic [31:0] ocr_inc;
	logic autoreload;
	logic ovf;
	logic match_hit;
	logic ocr_hit;
	logic [31:0] wdata;

	assign mapped = item.reg_index < 5'(NUM_REGS);
	assign wdata = item.write_data;
	assign cr = bank_q[R_TCRR];
	assign mar = bank_q[R_TMAR];
	assign nv = cr + STEP;
	assign ocr_inc = bank_q[R_TOCR] + 32'd1;
	assign autoreload = bank_q[R_TCLR][TCLR_AR_BIT];
	assign ovf = cr >= OVF_LIMIT;
	assign match_hit = (cr < mar) && (mar <= nv) && bank_q[R_TCLR][TCLR_CE_BIT]
		&& bank_q[R_TIER][TIER_MATCH_BIT];
	assign ocr_hit = bank_q[R_TIER][TIER_OVF_BIT]
		&& ((ocr_inc[23:0] & OCR_MASK) == (bank_q[R_TOWR][23:0] & OCR_MASK));

	always_comb begin
		rd_val = '0;
		if (mapped) begin
			if (item.reg_index == R_TTGR) begin
				rd_val = ALL_ONES;
			end else if (item.reg_index == R_TIOCP) begin
				rd_val = bank_q[R_TIOCP];
				rd_val[TIOCP_RD_MASK_BIT] = 1'b0;
			end else begin
				rd_val = bank_q[item.reg_index];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			bank_d[i] = bank_q[i];
		end
		armed_d = armed_q;
		result = '0;
		unique case (item.mode)
			MODE_READ: begin
				result.read_data = rd_val;
				result.unmapped = !mapped;
			end
			MODE_WRITE: begin
				if (!mapped) begin
					result.unmapped = 1'b1;
				end else begin
					unique case (reg_idx_t'(item.reg_index))
						R_TIOCP: begin
							if (wdata[TIOCP_SRST_BIT] && bank_q[R_TSICR][TSICR_SFT_BIT]) begin
								for (int i = 0; i < NUM_REGS; i++) begin
									bank_d[i] = reg_default(i);
								end
								armed_d = 1'b0;
							end else begin
								bank_d[R_TIOCP] = wdata;
							end
						end
						R_TISR: bank_d[R_TISR] = bank_q[R_TISR] & wdata;
						R_TCLR: begin
							bank_d[R_TCLR] = wdata;
							armed_d = wdata[TCLR_EN_BIT];
						end
						R_TCRR: begin
							if (cr != wdata) begin
								bank_d[R_TCRR] = wdata;
								armed_d = bank_q[R_TCLR][TCLR_EN_BIT];
							end
						end
						R_TTGR: begin
							bank_d[R_TTGR] = wdata;
							bank_d[R_TCRR] = bank_q[R_TLDR];
						end
						R_TIDR, R_TISTAT, R_TWPS, R_TCAR1: begin
						end
						default: bank_d[item.reg_index] = wdata;
					endcase
				end
			end
			MODE_TICK: begin
				if (armed_q) begin
					if (ovf) begin
						bank_d[R_TCRR] = autoreload ? bank_q[R_TLDR] : '0;
						if (ocr_hit) begin
							bank_d[R_TOCR] = '0;
							bank_d[R_TISR][TISR_OVF_BIT] = 1'b1;
							result.irq_pulse = 1'b1;
						end else begin
							bank_d[R_TOCR] = ocr_inc;
						end
					end else begin
						bank_d[R_TCRR] = nv;
						if (match_hit) begin
							bank_d[R_TISR][TISR_MATCH_BIT] = 1'b1;
							result.irq_pulse = 1'b1;
						end
					end
					if (!autoreload) begin
						armed_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				bank_q[i] <= reg_default(i);
			end
			armed_q <= 1'b0;
		end else if (fire) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				bank_q[i] <= bank_d[i];
			end
			armed_q <= armed_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/dmtr_out_reg.sv =====
`default_nettype none
module dmtr_out_reg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire dmtr_pkg::result_t result,
	output logic free,
	output logic out_valid,
	input wire logic out_ready,
	output dmtr_pkg::result_t out_result
);
	import dmtr_pkg::*;

	logic valid_q;
	result_t result_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign out_result = result_q;
endmodule
`default_nettype wire

// ===== design/dual_mode_timer_registers_unit.sv =====
// path: an accepted item waits in the input register, its result in the output register
// throughput: one item per cycle unless the output stalls; every register update
// finishes in the cycle the item leaves the input register
// reset: arst_n low clears both handshake stages and loads the register bank with
// its reset values at once, timer disarmed
`default_nettype none
module dual_mode_timer_registers_unit #(
	parameter int unsigned TICK_STEP = 24000
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [dmtr_pkg::S_TDATA_W-1:0] s_axis_tdata, // reg_index, write_data
	input wire logic [dmtr_pkg::S_TUSER_W-1:0] s_axis_tuser, // mode
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [dmtr_pkg::M_TDATA_W-1:0] m_axis_tdata, // read_data
	output logic [dmtr_pkg::M_TUSER_W-1:0] m_axis_tuser // irq_pulse, unmapped
);
	import dmtr_pkg::*;

	item_t in_item;
	item_t item_s1;
	logic valid_s1;
	logic advance;
	logic out_free;
	result_t result;
	result_t out_result;

	assign in_item.mode = mode_t'(s_axis_tuser);
	assign in_item.reg_index = s_axis_tdata[4:0];
	assign in_item.write_data = s_axis_tdata[36:5];

	assign advance = valid_s1 && out_free;

	dmtr_in_reg u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_item(in_item),
		.advance(advance),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	dmtr_regs #(
		.TICK_STEP(TICK_STEP)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.item(item_s1),
		.result(result)
	);

	dmtr_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance),
		.result(result),
		.free(out_free),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_result(out_result)
	);

	assign m_axis_tdata = out_result.read_data;
	assign m_axis_tuser = {out_result.unmapped, out_result.irq_pulse};
endmodule
`default_nettype wire

// ===== design/dmtr_checker.sv =====
`default_nettype none
module dmtr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [dmtr_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input wire logic [dmtr_pkg::S_TUSER_W-1:0] s_axis_tuser,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [dmtr_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input wire logic [dmtr_pkg::M_TUSER_W-1:0] m_axis_tuser
);
	import dmtr_pkg::*;

	// input side only backs up when a result is stuck at the output
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// interrupt comes from ticks, unmapped from bus accesses
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("irq and unmapped both set");

	a_flag_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]) |-> m_axis_tdata == '0)
		else $error("nonzero read data with irq or unmapped");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("stalled output item changed");
endmodule

bind dual_mode_timer_registers_unit dmtr_checker u_dmtr_checker (.*);
`default_nettype wire
